[sv/adcd_pkg.sv]
// Package: shared types, constants and phase codes of the animation delta command decoder.
package adcd_pkg;

	localparam logic [15:0] FRAME_BYTES   = 16'd64000;
	localparam logic [15:0] PALETTE_BYTES = 16'd768;
	localparam logic [15:0] BLOCK_MAX     = 16'd64000;
	localparam logic [7:0]  RUN_MARK      = 8'hC0;
	localparam logic [7:0]  RUN_MASK      = 8'h3F;
	localparam logic [7:0]  NUM_COMMANDS  = 8'd10;
	localparam int          QUEUE_DEPTH   = 2;

	// Command codes.
	localparam logic [3:0] C_FILL_PAL = 4'd0;
	localparam logic [3:0] C_RAW_PAL  = 4'd1;
	localparam logic [3:0] C_RLE_PAL  = 4'd2;
	localparam logic [3:0] C_COPY_PAL = 4'd3;
	localparam logic [3:0] C_FILL_FRM = 4'd4;
	localparam logic [3:0] C_RAW_FRM  = 4'd5;
	localparam logic [3:0] C_RLE_FRM  = 4'd6;
	localparam logic [3:0] C_POKE_FRM = 4'd7;
	localparam logic [3:0] C_SPAN_FRM = 4'd8;
	localparam logic [3:0] C_COPY_FRM = 4'd9;

	typedef enum logic [12:0] {
		PH_CMD       = 13'b0000000000001,
		PH_FILL      = 13'b0000000000010,
		PH_RAW       = 13'b0000000000100,
		PH_RLE_CODE  = 13'b0000000001000,
		PH_RLE_VALUE = 13'b0000000010000,
		PH_COUNT_LO  = 13'b0000000100000,
		PH_COUNT_HI  = 13'b0000001000000,
		PH_OFF_LO    = 13'b0000010000000,
		PH_OFF_HI    = 13'b0000100000000,
		PH_LEN_LO    = 13'b0001000000000,
		PH_LEN_HI    = 13'b0010000000000,
		PH_VALUE     = 13'b0100000000000,
		PH_COPY      = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        block_start;
		logic [15:0] block_length;
		logic [15:0] command_count;
	} in_item_t;

	typedef struct packed {
		logic        write_valid;
		logic        to_frame;
		logic [15:0] start_address;
		logic [15:0] span_length;
		logic [7:0]  fill_value;
		logic        block_done;
	} out_item_t;

	// Classified byte handed from the front to the back.
	typedef struct packed {
		logic        block_start;
		logic        empty_block;
		logic [7:0]  data_byte;
		logic [15:0] block_length;
		logic [15:0] command_count;
	} tok_t;

endpackage

[sv/adcd_front.sv]
// Front end: accept input transfers, clamp the block length and mark empty blocks.
module adcd_front import adcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	output logic     tok_valid,
	input  logic     tok_stall,
	output tok_t     tok
);
	logic [15:0] len;

	always_comb begin
		len = (in_item.block_length > BLOCK_MAX) ? BLOCK_MAX : in_item.block_length;
	end

	assign in_stall = tok_valid && tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid <= 1'b0;
		end else if (!in_stall) begin
			tok_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			tok.block_start   <= in_item.block_start;
			tok.empty_block   <= in_item.block_start &&
				(len == 16'd0 || in_item.command_count == 16'd0);
			tok.data_byte     <= in_item.data_byte;
			tok.block_length  <= len;
			tok.command_count <= in_item.command_count;
		end
	end
endmodule

[sv/adcd_queue.sv]
// Small two-entry queue between front and back.
module adcd_queue import adcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_stall,
	input  tok_t wr_data,
	output logic rd_valid,
	input  logic rd_stall,
	output tok_t rd_data
);
	tok_t       mem [QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_stall = (cnt_q == 2'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[sv/adcd_back.sv]
// Back end: command parser that turns classified bytes into span writes.
module adcd_back import adcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tok_valid,
	output logic      tok_stall,
	input  tok_t      tok,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	phase_t      phase_q, ph;
	logic [3:0]  cmd_q, cmd;
	logic [15:0] bytes_q, bytes_n;
	logic [15:0] cmds_q, cmds;
	logic [15:0] recs_q, recs;
	logic [15:0] cur_q, cur;
	logic [15:0] off_q, off;
	logic [15:0] rlen_q, rlen;
	logic        allow_q, allow;
	out_item_t   res;
	logic        take;
	logic [15:0] rem, lim, n;
	logic [16:0] sum;
	logic        frame;

	assign tok_stall = out_valid && out_stall;
	assign take      = tok_valid && !tok_stall;

	function automatic phase_t recs_phase(input logic [3:0] c, input logic [15:0] r,
		input logic [15:0] rm);
		logic [15:0] need;
		need = (c == C_SPAN_FRM) ? 16'd5 : 16'd4;
		return (r != 16'd0 && rm >= need) ? PH_OFF_LO : PH_CMD;
	endfunction

	always_comb begin
		ph = phase_q; cmd = cmd_q; bytes_n = bytes_q; cmds = cmds_q; recs = recs_q;
		cur = cur_q; off = off_q; rlen = rlen_q; allow = allow_q;
		res = '0; rem = 16'd0; n = 16'd0; sum = 17'd0;
		if (tok.block_start) begin
			ph = PH_CMD; cmd = C_FILL_PAL; recs = 16'd0; cur = 16'd0; off = 16'd0;
			rlen = 16'd0; allow = 1'b0;
			bytes_n = tok.empty_block ? 16'd0 : tok.block_length;
			cmds = tok.empty_block ? 16'd0 : tok.command_count;
		end
		frame = (cmd >= C_FILL_FRM);
		lim = frame ? FRAME_BYTES : PALETTE_BYTES;
		if (tok.empty_block) begin
			res.block_done = 1'b1;
		end else if (bytes_n != 16'd0) begin
			bytes_n = bytes_n - 16'd1;
			rem = bytes_n;
			case (ph)
				PH_CMD: begin
					if (cmds != 16'd0) cmds = cmds - 16'd1;
					if (tok.data_byte < NUM_COMMANDS) begin
						cmd = tok.data_byte[3:0];
						frame = (cmd >= C_FILL_FRM);
						lim = frame ? FRAME_BYTES : PALETTE_BYTES;
						case (cmd)
							C_FILL_PAL, C_FILL_FRM: if (rem != 16'd0) ph = PH_FILL;
							C_RAW_PAL, C_RAW_FRM: begin
								n = (rem < lim) ? rem : lim;
								cur = 16'd0; rlen = n;
								if (n != 16'd0) ph = PH_RAW;
							end
							C_RLE_PAL, C_RLE_FRM: begin
								cur = 16'd0;
								if (rem != 16'd0) ph = PH_RLE_CODE;
							end
							C_COPY_PAL: if (rem != 16'd0) ph = PH_COUNT_LO;
							default: if (rem >= 16'd2) ph = PH_COUNT_LO;
						endcase
					end
				end
				PH_FILL: begin
					res = '{1'b1, frame, 16'd0, lim, tok.data_byte, 1'b0};
					ph = PH_CMD;
				end
				PH_RAW: begin
					res = '{1'b1, frame, cur, 16'd1, tok.data_byte, 1'b0};
					cur = cur + 16'd1; rlen = rlen - 16'd1;
					if (rlen == 16'd0) ph = PH_CMD;
				end
				PH_RLE_CODE, PH_RLE_VALUE: begin
					if (ph == PH_RLE_CODE && (tok.data_byte & RUN_MARK) == RUN_MARK) begin
						rlen = {8'd0, tok.data_byte & RUN_MASK};
						ph = PH_RLE_VALUE;
					end else begin
						if (ph == PH_RLE_CODE) begin
							res = '{1'b1, frame, cur, 16'd1, tok.data_byte, 1'b0};
							cur = cur + 16'd1;
						end else begin
							ph = PH_RLE_CODE;
							if (rem != 16'd0 && rlen != 16'd0 && cur < lim) begin
								n = lim - cur;
								if (rlen < n) n = rlen;
								res = '{1'b1, frame, cur, n, tok.data_byte, 1'b0};
								cur = cur + n;
							end
						end
						if (cur >= lim || rem == 16'd0) ph = PH_CMD;
					end
				end
				PH_COUNT_LO: begin
					recs = {8'd0, tok.data_byte};
					ph = (cmd == C_COPY_PAL) ? recs_phase(cmd, recs, rem) : PH_COUNT_HI;
				end
				PH_COUNT_HI: begin
					recs = {tok.data_byte, recs[7:0]};
					ph = recs_phase(cmd, recs, rem);
				end
				PH_OFF_LO: begin off = {8'd0, tok.data_byte}; ph = PH_OFF_HI; end
				PH_OFF_HI: begin off = {tok.data_byte, off[7:0]}; ph = PH_LEN_LO; end
				PH_LEN_LO: begin rlen = {8'd0, tok.data_byte}; ph = PH_LEN_HI; end
				PH_LEN_HI: begin
					rlen = {tok.data_byte, rlen[7:0]};
					if (cmd == C_POKE_FRM) begin
						if (off < FRAME_BYTES)
							res = '{1'b1, frame, off, 16'd1, rlen[7:0], 1'b0};
						recs = recs - 16'd1;
						ph = recs_phase(cmd, recs, rem);
					end else if (cmd == C_SPAN_FRM) begin
						ph = PH_VALUE;
					end else begin
						sum = {1'b0, off} + {1'b0, rlen};
						allow = (rlen != 16'd0) && (sum <= {1'b0, lim}) && (rlen <= rem);
						cur = off;
						if (rlen == 16'd0) begin
							recs = recs - 16'd1;
							ph = recs_phase(cmd, recs, rem);
						end else begin
							ph = PH_COPY;
						end
					end
				end
				PH_VALUE: begin
					if (off < FRAME_BYTES && rlen != 16'd0) begin
						n = FRAME_BYTES - off;
						if (rlen < n) n = rlen;
						res = '{1'b1, frame, off, n, tok.data_byte, 1'b0};
					end
					recs = recs - 16'd1;
					ph = recs_phase(cmd, recs, rem);
				end
				PH_COPY: begin
					if (allow) res = '{1'b1, frame, cur, 16'd1, tok.data_byte, 1'b0};
					cur = cur + 16'd1; rlen = rlen - 16'd1;
					if (rlen == 16'd0) begin
						recs = recs - 16'd1;
						ph = recs_phase(cmd, recs, rem);
					end
				end
				default: ph = PH_CMD;
			endcase
			if (bytes_n == 16'd0 || (ph == PH_CMD && cmds == 16'd0)) begin
				res.block_done = 1'b1;
				bytes_n = 16'd0; cmds = 16'd0; ph = PH_CMD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD; cmd_q <= C_FILL_PAL; bytes_q <= 16'd0; cmds_q <= 16'd0;
			recs_q <= 16'd0; cur_q <= 16'd0; off_q <= 16'd0; rlen_q <= 16'd0;
			allow_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (!tok_stall) out_valid <= take;
			if (take) begin
				phase_q <= ph; cmd_q <= cmd; bytes_q <= bytes_n; cmds_q <= cmds;
				recs_q <= recs; cur_q <= cur; off_q <= off; rlen_q <= rlen;
				allow_q <= allow;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_item <= res;
	end
endmodule

[sv/animation_delta_command_decoder.sv]
// Top level of the animation delta command decoder.
// A result passes the front register, a queue entry and the result register
// before it is offered. Throughput: one byte per cycle unless the output stalls;
// every byte gives exactly one result transfer.
// The parser state update in the back end is the per-byte loop that sets this rate.
// Reset (arst_n low, asynchronous): parser waits for a block, queue empties, no result valid.
module animation_delta_command_decoder import adcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	// Front to queue, queue to back.
	logic f_valid, f_stall, q_valid, q_stall;
	tok_t f_tok, q_tok;

	// Accept and classify each transfer.
	adcd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .tok_valid(f_valid), .tok_stall(f_stall), .tok(f_tok)
	);

	// Decouple the two halves so each may stall on its own.
	adcd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_stall(f_stall),
		.wr_data(f_tok), .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_tok)
	);

	// Parse commands and emit span writes.
	adcd_back u_back (
		.clk(clk), .arst_n(arst_n), .tok_valid(q_valid), .tok_stall(q_stall),
		.tok(q_tok), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule

[bench/animation_delta_command_decoder_tb.sv]
// Testbench for the animation delta command decoder: directed and random blocks against a predictor.
module animation_delta_command_decoder_tb;
	import adcd_pkg::*;

	// Parser phases of the predictor.
	typedef enum logic [3:0] {
		P_CMD, P_FILL, P_RAW, P_RLE_CODE, P_RLE_VALUE, P_COUNT_LO, P_COUNT_HI,
		P_OFF_LO, P_OFF_HI, P_LEN_LO, P_LEN_HI, P_VALUE, P_COPY
	} pred_phase_t;

	localparam int LONG_HOLD   = 60;
	localparam int TAIL_WAIT   = 10;
	localparam int ITEM_TARGET = 1030;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	animation_delta_command_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	// Predictor state.
	pred_phase_t phase;
	logic [3:0]  cmd;
	int unsigned left_bytes, left_cmds, left_recs, cursor, rec_off, rec_len;
	bit          copy_ok;

	out_item_t   span_queue[$];
	int          errors = 0;
	int          results_seen = 0;
	int          spans_seen = 0;
	int          items_sent = 0;
	bit          sender_idle_on = 1;
	bit          recv_idle_on = 1;
	int          hold_cycles = 0;
	int          hold_req = 0;
	int          hold_ack = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int unsigned store_bytes();
		return (cmd >= C_FILL_FRM) ? 64000 : 768;
	endfunction

	function automatic void clear_decoder();
		phase = P_CMD; cmd = C_FILL_PAL; left_recs = 0; cursor = 0;
		rec_off = 0; rec_len = 0; copy_ok = 0;
	endfunction

	function automatic void open_records(int unsigned rem);
		int unsigned need;
		need = (cmd == C_SPAN_FRM) ? 5 : 4;
		phase = (left_recs != 0 && rem >= need) ? P_OFF_LO : P_CMD;
	endfunction

	function automatic void put_span(ref out_item_t o, input int unsigned a,
			input int unsigned n, input int unsigned v);
		o.write_valid = 1'b1;
		o.to_frame = (cmd >= C_FILL_FRM);
		o.start_address = a[15:0];
		o.span_length = n[15:0];
		o.fill_value = v[7:0];
	endfunction

	// Work out the one result that a byte transfer causes.
	function automatic out_item_t decode_byte(in_item_t it);
		out_item_t o;
		int unsigned b, rem, lim, n, len;
		o = '0;
		b = it.data_byte;
		if (it.block_start) begin
			len = it.block_length;
			if (len > 64000) len = 64000;
			clear_decoder();
			if (len == 0 || it.command_count == 0) begin
				left_bytes = 0; left_cmds = 0;
				o.block_done = 1'b1;
				return o;
			end
			left_bytes = len;
			left_cmds = it.command_count;
		end
		if (left_bytes == 0) return o;
		left_bytes--;
		rem = left_bytes;
		lim = store_bytes();
		case (phase)
			P_CMD: begin
				if (left_cmds != 0) left_cmds--;
				if (b < NUM_COMMANDS) begin
					cmd = b[3:0];
					lim = store_bytes();
					case (cmd)
						C_FILL_PAL, C_FILL_FRM: if (rem > 0) phase = P_FILL;
						C_RAW_PAL, C_RAW_FRM: begin
							n = rem < lim ? rem : lim;
							cursor = 0; rec_len = n;
							if (n > 0) phase = P_RAW;
						end
						C_RLE_PAL, C_RLE_FRM: begin
							cursor = 0;
							if (rem > 0) phase = P_RLE_CODE;
						end
						C_COPY_PAL: if (rem > 0) phase = P_COUNT_LO;
						default: if (rem >= 2) phase = P_COUNT_LO;
					endcase
				end
			end
			P_FILL: begin
				put_span(o, 0, lim, b);
				phase = P_CMD;
			end
			P_RAW: begin
				put_span(o, cursor, 1, b);
				cursor = (cursor + 1) & 16'hFFFF;
				rec_len = (rec_len - 1) & 16'hFFFF;
				if (rec_len == 0) phase = P_CMD;
			end
			P_RLE_CODE, P_RLE_VALUE: begin
				if (phase == P_RLE_CODE && (b & RUN_MARK) == RUN_MARK) begin
					rec_len = b & RUN_MASK;
					phase = P_RLE_VALUE;
				end else begin
					if (phase == P_RLE_CODE) begin
						put_span(o, cursor, 1, b);
						cursor++;
					end else begin
						phase = P_RLE_CODE;
						if (rem > 0 && rec_len > 0 && cursor < lim) begin
							n = lim - cursor;
							if (rec_len < n) n = rec_len;
							put_span(o, cursor, n, b);
							cursor += n;
						end
					end
					if (cursor >= lim || rem == 0) phase = P_CMD;
				end
			end
			P_COUNT_LO: begin
				left_recs = b;
				if (cmd == C_COPY_PAL) open_records(rem);
				else phase = P_COUNT_HI;
			end
			P_COUNT_HI: begin
				left_recs |= b << 8;
				open_records(rem);
			end
			P_OFF_LO: begin rec_off = b; phase = P_OFF_HI; end
			P_OFF_HI: begin rec_off |= b << 8; phase = P_LEN_LO; end
			P_LEN_LO: begin rec_len = b; phase = P_LEN_HI; end
			P_LEN_HI: begin
				rec_len |= b << 8;
				if (cmd == C_POKE_FRM) begin
					if (rec_off < 64000) put_span(o, rec_off, 1, rec_len);
					left_recs = (left_recs - 1) & 16'hFFFF;
					open_records(rem);
				end else if (cmd == C_SPAN_FRM) begin
					phase = P_VALUE;
				end else begin
					copy_ok = rec_len > 0 && rec_off + rec_len <= lim && rec_len <= rem;
					cursor = rec_off;
					if (rec_len == 0) begin
						left_recs = (left_recs - 1) & 16'hFFFF;
						open_records(rem);
					end else begin
						phase = P_COPY;
					end
				end
			end
			P_VALUE: begin
				if (rec_off < 64000 && rec_len > 0) begin
					n = 64000 - rec_off;
					if (rec_len < n) n = rec_len;
					put_span(o, rec_off, n, b);
				end
				left_recs = (left_recs - 1) & 16'hFFFF;
				open_records(rem);
			end
			P_COPY: begin
				if (copy_ok) put_span(o, cursor, 1, b);
				cursor = (cursor + 1) & 16'hFFFF;
				rec_len = (rec_len - 1) & 16'hFFFF;
				if (rec_len == 0) begin
					left_recs = (left_recs - 1) & 16'hFFFF;
					open_records(rem);
				end
			end
			default: phase = P_CMD;
		endcase
		if (left_bytes == 0 || (phase == P_CMD && left_cmds == 0)) begin
			o.block_done = 1'b1;
			left_bytes = 0; left_cmds = 0; phase = P_CMD;
		end
		return o;
	endfunction

	// Offer one byte, hold it until the transfer, and record the expected result.
	// Valid stays high on return; the next call replaces the byte, and drain() drops valid.
	task automatic send_byte(input logic [7:0] b, input bit first = 0,
			input logic [15:0] blen = 16'd0, input logic [15:0] ncmd = 16'd0);
		int gap;
		if (sender_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item.data_byte <= b;
		in_item.block_start <= first;
		in_item.block_length <= first ? blen : 16'($urandom);
		in_item.command_count <= first ? ncmd : 16'($urandom);
		// Advance on the rising edge that takes the transfer.
		do @(posedge clk); while (in_stall);
		span_queue.push_back(decode_byte('{b, first, blen, ncmd}));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_block(input logic [7:0] bytes[$], input logic [15:0] ncmd);
		for (int i = 0; i < bytes.size(); i++)
			send_byte(bytes[i], i == 0, 16'(bytes.size()), ncmd);
	endtask

	// Drop valid and wait until every expected result has come.
	task automatic drain();
		in_valid <= 1'b0;
		while (span_queue.size() != 0) @(negedge clk);
	endtask

	// Receiver: random hold-off bursts, plus one long hold when asked.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (recv_idle_on && $urandom_range(0, 6) == 0) begin
			hold_cycles <= $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (span_queue.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				out_item_t e;
				e = span_queue.pop_front();
				results_seen++;
				if (e.write_valid) spans_seen++;
				if (out_item.write_valid !== e.write_valid) begin
					$error("write_valid exp %0d got %0d", e.write_valid, out_item.write_valid);
					errors++;
				end
				if (out_item.to_frame !== e.to_frame) begin
					$error("to_frame exp %0d got %0d", e.to_frame, out_item.to_frame);
					errors++;
				end
				if (out_item.start_address !== e.start_address) begin
					$error("start_address exp %0d got %0d", e.start_address,
						out_item.start_address);
					errors++;
				end
				if (out_item.span_length !== e.span_length) begin
					$error("span_length exp %0d got %0d", e.span_length, out_item.span_length);
					errors++;
				end
				if (out_item.fill_value !== e.fill_value) begin
					$error("fill_value exp %0d got %0d", e.fill_value, out_item.fill_value);
					errors++;
				end
				if (out_item.block_done !== e.block_done) begin
					$error("block_done exp %0d got %0d", e.block_done, out_item.block_done);
					errors++;
				end
			end
		end
	end

	// Directed: fills, raw copies, runs and unknown commands.
	task automatic test_basic_commands();
		send_block('{8'(C_FILL_PAL), 8'hFF, 8'(C_FILL_FRM), 8'h00, 8'd200}, 16'd3);
		send_block('{8'(C_RAW_FRM), 8'hA5, 8'h5A, 8'h01}, 16'd1);
		send_block('{8'(C_RLE_PAL), 8'h33, 8'hC5, 8'h7E, 8'hC0, 8'h11, 8'hFF}, 16'd1);
		send_byte(8'h44);                // stray byte with no open block
		send_block('{8'd0}, 16'd0);      // empty block by command count
		drain();
	endtask

	// Directed: record commands with drops, clipping and short records.
	task automatic test_record_commands();
		send_block('{8'(C_POKE_FRM), 8'd2, 8'd0, 8'hFF, 8'hF9, 8'h12, 8'h00,
			8'h00, 8'hFA, 8'h34, 8'h00}, 16'd1);
		send_block('{8'(C_SPAN_FRM), 8'd1, 8'd0, 8'hFE, 8'hF9, 8'h10, 8'h00, 8'h77},
			16'd1);
		send_block('{8'(C_COPY_PAL), 8'd1, 8'hFE, 8'h02, 8'h02, 8'h00, 8'h01, 8'h02},
			16'd1);
		send_block('{8'(C_COPY_FRM), 8'd1, 8'd0, 8'd5, 8'd0, 8'd9, 8'd0, 8'hAB}, 16'd1);
		send_block('{8'(C_POKE_FRM), 8'd3}, 16'd2);
		drain();
	endtask

	// Build a well formed record-heavy block with random content, or noise.
	task automatic random_block();
		logic [7:0] bytes[$];
		int ncmd, k;
		logic [3:0] c;
		ncmd = $urandom_range(1, 6);
		for (int i = 0; i < ncmd; i++) begin
			c = 4'($urandom_range(0, 11));
			bytes.push_back(8'(c));
			case (c)
				C_FILL_PAL, C_FILL_FRM: bytes.push_back(8'($urandom));
				C_RAW_PAL, C_RAW_FRM, C_RLE_PAL, C_RLE_FRM:
					repeat ($urandom_range(0, 8)) bytes.push_back(
						$urandom_range(0, 2) == 0 ? RUN_MARK | 8'($urandom) : 8'($urandom));
				C_COPY_PAL, C_COPY_FRM, C_POKE_FRM, C_SPAN_FRM: begin
					k = $urandom_range(0, 3);
					bytes.push_back(8'(k));
					if (c != C_COPY_PAL) bytes.push_back(8'd0);
					repeat (k) begin
						bytes.push_back(8'($urandom));
						bytes.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'hFA);
						bytes.push_back(8'($urandom_range(0, 4)));
						bytes.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'd0);
						if (c == C_SPAN_FRM) bytes.push_back(8'($urandom));
						else if (c != C_POKE_FRM)
							repeat ($urandom_range(0, 4)) bytes.push_back(8'($urandom));
					end
				end
				default: ;
			endcase
		end
		// Sometimes truncate, or miscount the commands, to break the sequence.
		if ($urandom_range(0, 4) == 0 && bytes.size() > 1)
			bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
		if ($urandom_range(0, 5) == 0) ncmd = $urandom_range(1, 65535);
		send_block(bytes, 16'(ncmd));
	endtask

	// Random traffic, with a long receiver hold and a sender pause in the middle.
	task automatic test_random_traffic();
		bit held, paused;
		held = 0;
		paused = 0;
		while (items_sent < ITEM_TARGET) begin
			if (!held && items_sent > 400) begin
				held = 1;
				hold_req++;
			end
			if (!paused && items_sent > 600) begin
				paused = 1;
				drain();
			end
			if (items_sent > 850) begin
				sender_idle_on = 0; recv_idle_on = 0;
			end
			random_block();
			if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
			if ($urandom_range(0, 19) == 0)
				send_byte(8'($urandom), 1, $urandom_range(0, 1) ? 16'hFFFF : 16'd0,
					16'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_basic_commands();
		test_record_commands();
		test_random_traffic();
		drain();
		repeat (TAIL_WAIT) @(negedge clk);
		$display("Checked %0d byte results, %0d of them span writes, over all ten commands",
			results_seen, spans_seen);
		if (errors == 0)
			$display("animation_delta_command_decoder_tb: PASS");
		else
			$display("animation_delta_command_decoder_tb: FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("animation_delta_command_decoder_tb: FAIL");
		$finish;
	end

endmodule
